### rtl/okle_pkg.sv
// Shared types and constants for the ordered key list engine.
`default_nettype none
package okle_pkg;

	localparam int unsigned DEF_CAPACITY = 16;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned ACT_W        = 4;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned POS_W        = 4;
	localparam int unsigned ENTRY_W      = 5;

	localparam logic [ACT_W-1:0] ACT_CLEAR    = 4'd0;
	localparam logic [ACT_W-1:0] ACT_SORT_INS = 4'd1;
	localparam logic [ACT_W-1:0] ACT_TAIL_INS = 4'd2;
	localparam logic [ACT_W-1:0] ACT_HEAD_INS = 4'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_KEY  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 4'd5;
	localparam logic [ACT_W-1:0] ACT_DEL_TAIL = 4'd6;
	localparam logic [ACT_W-1:0] ACT_REVERSE  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_DUMP     = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	typedef enum logic [3:0] {
		M_HOLD,
		M_EVAL,
		M_SORT,
		M_TAIL,
		M_HEAD,
		M_DEL_KEY,
		M_DEL_HEAD,
		M_REV,
		M_ROT
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [KEY_W-1:0]  key;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_REV,
		S_DUMP
	} state_t;

endpackage
`default_nettype wire

### rtl/ordered_key_list_engine.sv
// Top level of the ordered key list engine: command sequencer and row of cells.
//
//  channel  | handshake            | signals
//  ---------+----------------------+---------------------------------------------
//  command  | start & !busy        | action, new_key
//  result   | done                 | status, key_out, position, entry_count, last
//
// Edit commands first register every cell's compare flags, then shift the row.
// Reverse then moves the tail into each slot in turn (one tail rotation per
// step), and dump rotates the row once per entry to put each one out.
// The next command is taken in the cycle its predecessor's final result shows.
// Reset clears the entry count; cell contents stay unknown until written.
// Results cannot be stalled; each is valid only while done is high.
`default_nettype none
module ordered_key_list_engine #(
	parameter int unsigned CAPACITY = okle_pkg::DEF_CAPACITY
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire         [okle_pkg::ACT_W-1:0]     action,
	input  wire  signed [okle_pkg::KEY_W-1:0]     new_key,
	output logic                                  done,
	output logic        [okle_pkg::STATUS_W-1:0]  status,
	output logic signed [okle_pkg::KEY_W-1:0]     key_out,
	output logic        [okle_pkg::POS_W-1:0]     position,
	output logic        [okle_pkg::ENTRY_W-1:0]   entry_count,
	output logic                                  last
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	okle_pkg::state_t              state_q, state_n;
	logic [okle_pkg::ACT_W-1:0]    action_q;
	logic [okle_pkg::KEY_W-1:0]    key_q;
	logic [CW-1:0]                 count_q, count_n;
	logic [IW-1:0]                 step_q, step_n;

	logic                          done_q, done_n;
	logic [okle_pkg::STATUS_W-1:0] status_q, status_n;
	logic [okle_pkg::KEY_W-1:0]    key_out_q, key_out_n;
	logic [okle_pkg::POS_W-1:0]    position_q, position_n;
	logic                          last_q, last_n;

	okle_pkg::cell_cmd_t           cmd;
	logic [okle_pkg::KEY_W-1:0]    cell_key [CAPACITY];
	logic                          ge_chain [CAPACITY];
	logic                          eq_chain [CAPACITY];
	logic                          ge_last;
	logic                          found;
	logic [okle_pkg::KEY_W-1:0]    head_key;
	logic [okle_pkg::KEY_W-1:0]    tail_key;
	logic [IW-1:0]                 tail_idx;
	logic                          full;
	logic                          empty;
	logic                          accept;

	assign accept   = start && !busy;
	assign busy     = state_q != okle_pkg::S_IDLE;
	assign full     = count_q == CW'(CAPACITY);
	assign empty    = count_q == '0;
	assign tail_idx = IW'(count_q - CW'(1));
	assign head_key = cell_key[0];
	assign tail_key = cell_key[tail_idx];

	assign done        = done_q;
	assign status      = status_q;
	assign key_out     = key_out_q;
	assign position    = position_q;
	assign entry_count = okle_pkg::ENTRY_W'(count_q);
	assign last        = last_q;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [okle_pkg::KEY_W-1:0] left_k;
			logic [okle_pkg::KEY_W-1:0] right_k;
			logic                       ge_i;
			logic                       eq_i;
			logic                       ge_o;
			logic                       eq_o;

			if (gi == 0) begin : g_first
				assign left_k = cell_key[0];
				assign ge_i   = 1'b0;
				assign eq_i   = 1'b0;
			end else begin : g_mid
				assign left_k = cell_key[gi-1];
				assign ge_i   = ge_chain[gi-1];
				assign eq_i   = eq_chain[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign right_k = cell_key[gi];
			end else begin : g_inner
				assign right_k = cell_key[gi+1];
			end

			assign ge_chain[gi] = ge_o;
			assign eq_chain[gi] = eq_o;

			okle_cell #(
				.CAPACITY(CAPACITY)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.idx       (IW'(gi)),
				.count     (count_q),
				.step      (step_q),
				.left_key  (left_k),
				.right_key (right_k),
				.head_key  (head_key),
				.tail_key  (tail_key),
				.ge_in     (ge_i),
				.eq_in     (eq_i),
				.ge_out    (ge_o),
				.eq_out    (eq_o),
				.key       (cell_key[gi])
			);
		end
	endgenerate

	assign ge_last = ge_chain[CAPACITY-1];
	assign found   = eq_chain[CAPACITY-1];

	always_comb begin
		state_n    = state_q;
		count_n    = count_q;
		step_n     = step_q;
		done_n     = 1'b0;
		status_n   = okle_pkg::ST_OK;
		key_out_n  = '0;
		position_n = '0;
		last_n     = 1'b1;
		cmd.mode   = okle_pkg::M_HOLD;
		cmd.key    = key_q;
		case (state_q)
			okle_pkg::S_IDLE: begin
				if (accept)
					state_n = okle_pkg::S_EVAL;
			end
			okle_pkg::S_EVAL: begin
				cmd.mode = okle_pkg::M_EVAL;
				state_n  = okle_pkg::S_APPLY;
			end
			okle_pkg::S_APPLY: begin
				done_n  = 1'b1;
				state_n = okle_pkg::S_IDLE;
				case (action_q)
					okle_pkg::ACT_CLEAR: begin
						count_n = '0;
					end
					okle_pkg::ACT_SORT_INS, okle_pkg::ACT_TAIL_INS,
					okle_pkg::ACT_HEAD_INS: begin
						if (full) begin
							status_n = okle_pkg::ST_FULL;
						end else begin
							count_n = count_q + CW'(1);
							if (action_q == okle_pkg::ACT_SORT_INS)
								cmd.mode = okle_pkg::M_SORT;
							else if (action_q == okle_pkg::ACT_TAIL_INS)
								cmd.mode = okle_pkg::M_TAIL;
							else
								cmd.mode = okle_pkg::M_HEAD;
						end
					end
					okle_pkg::ACT_DEL_KEY: begin
						if (empty) begin
							status_n = okle_pkg::ST_EMPTY;
						end else if (found) begin
							cmd.mode  = okle_pkg::M_DEL_KEY;
							count_n   = count_q - CW'(1);
							key_out_n = key_q;
						end else begin
							status_n = okle_pkg::ST_NOTFOUND;
						end
					end
					okle_pkg::ACT_DEL_HEAD: begin
						if (empty) begin
							status_n = okle_pkg::ST_EMPTY;
						end else begin
							cmd.mode  = okle_pkg::M_DEL_HEAD;
							count_n   = count_q - CW'(1);
							key_out_n = head_key;
						end
					end
					okle_pkg::ACT_DEL_TAIL: begin
						if (empty) begin
							status_n = okle_pkg::ST_EMPTY;
						end else begin
							count_n   = count_q - CW'(1);
							key_out_n = tail_key;
						end
					end
					okle_pkg::ACT_REVERSE: begin
						if (empty) begin
							status_n = okle_pkg::ST_EMPTY;
						end else if (count_q != CW'(1)) begin
							done_n  = 1'b0;
							step_n  = '0;
							state_n = okle_pkg::S_REV;
						end
					end
					okle_pkg::ACT_DUMP: begin
						if (empty) begin
							status_n = okle_pkg::ST_EMPTY;
						end else begin
							done_n  = 1'b0;
							step_n  = '0;
							state_n = okle_pkg::S_DUMP;
						end
					end
					default: begin
					end
				endcase
			end
			okle_pkg::S_REV: begin
				cmd.mode = okle_pkg::M_REV;
				if (CW'(step_q) == count_q - CW'(2)) begin
					done_n  = 1'b1;
					state_n = okle_pkg::S_IDLE;
				end else begin
					step_n = step_q + IW'(1);
				end
			end
			okle_pkg::S_DUMP: begin
				// head goes out, row rotates so the next entry reaches the head
				cmd.mode   = okle_pkg::M_ROT;
				done_n     = 1'b1;
				key_out_n  = head_key;
				position_n = okle_pkg::POS_W'(step_q);
				last_n     = CW'(step_q) == count_q - CW'(1);
				if (last_n)
					state_n = okle_pkg::S_IDLE;
				else
					step_n = step_q + IW'(1);
			end
			default: begin
				state_n = okle_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= okle_pkg::S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			step_q  <= step_n;
			done_q  <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= new_key;
		end
		status_q   <= status_n;
		key_out_q  <= key_out_n;
		position_q <= position_n;
		last_q     <= last_n;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_final_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && last_q |=> !done_q)
		else $error("result after final result of a command");

	a_mid_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !last_q |-> busy)
		else $error("non-final result while sequencer idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer did not start the sequencer");

	a_ge_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == okle_pkg::S_APPLY && ge_last |-> count_q != '0)
		else $error("compare flag set in an empty list");

endmodule
`default_nettype wire

### rtl/okle_cell.sv
// One list cell: holds a key, compares it, and shifts with its neighbors.
`default_nettype none
module okle_cell #(
	parameter int unsigned CAPACITY = okle_pkg::DEF_CAPACITY,
	localparam int unsigned IW = $clog2(CAPACITY),
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  okle_pkg::cell_cmd_t      cmd,
	input  wire  [IW-1:0]                  idx,
	input  wire  [CW-1:0]                  count,
	input  wire  [IW-1:0]                  step,
	input  wire  [okle_pkg::KEY_W-1:0]     left_key,
	input  wire  [okle_pkg::KEY_W-1:0]     right_key,
	input  wire  [okle_pkg::KEY_W-1:0]     head_key,
	input  wire  [okle_pkg::KEY_W-1:0]     tail_key,
	input  wire                            ge_in,
	input  wire                            eq_in,
	output logic                           ge_out,
	output logic                           eq_out,
	output logic [okle_pkg::KEY_W-1:0]     key
);

	logic [okle_pkg::KEY_W-1:0] key_q;
	logic [okle_pkg::KEY_W-1:0] key_n;
	logic                       ge_q;
	logic                       eq_q;
	logic [CW-1:0]              idx_c;
	logic                       in_list;

	assign idx_c   = CW'(idx);
	assign in_list = idx_c < count;
	assign ge_out  = ge_in | ge_q;
	assign eq_out  = eq_in | eq_q;
	assign key     = key_q;

	always_comb begin
		key_n = key_q;
		case (cmd.mode)
			okle_pkg::M_SORT: begin
				// everything from the first key >= new key moves one place up
				if (ge_in)
					key_n = left_key;
				else if (ge_q || idx_c == count)
					key_n = cmd.key;
			end
			okle_pkg::M_TAIL: begin
				if (idx_c == count)
					key_n = cmd.key;
			end
			okle_pkg::M_HEAD: begin
				key_n = (idx == '0) ? cmd.key : left_key;
			end
			okle_pkg::M_DEL_KEY: begin
				if (eq_in || eq_q)
					key_n = right_key;
			end
			okle_pkg::M_DEL_HEAD: begin
				key_n = right_key;
			end
			okle_pkg::M_REV: begin
				// tail moves to slot step, the span behind it shifts up
				if (idx == step)
					key_n = tail_key;
				else if (idx > step && in_list)
					key_n = left_key;
			end
			okle_pkg::M_ROT: begin
				if (idx_c == count - CW'(1))
					key_n = head_key;
				else if (in_list)
					key_n = right_key;
			end
			default: key_n = key_q;
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.mode == okle_pkg::M_EVAL) begin
			ge_q <= in_list && ($signed(key_q) >= $signed(cmd.key));
			eq_q <= in_list && (key_q == cmd.key);
		end
	end

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for the ordered key list engine: random command traffic checked against a list model.
`timescale 1ns / 100ps
module tb;
	import okle_pkg::*;

	localparam int CAP = DEF_CAPACITY;
	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_DUMP + 1'b1;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic signed [KEY_W-1:0]   key;
		logic [POS_W-1:0]          pos;
		logic [ENTRY_W-1:0]        count;
		logic                      last;
	} list_result_t;

	class key_list_tracker;
		logic signed [KEY_W-1:0] cells [CAP];
		int held;
		int fails;
		list_result_t due[$];

		function new();
			held = 0;
			fails = 0;
		endfunction

		function void push(logic [STATUS_W-1:0] st, logic signed [KEY_W-1:0] key, int pos,
				logic is_last);
			list_result_t r;
			r = '{st, key, POS_W'(pos), ENTRY_W'(held), is_last};
			due.push_back(r);
		endfunction

		function void place(int idx, logic signed [KEY_W-1:0] key);
			for (int i = held; i > idx; i--)
				cells[i] = cells[i-1];
			cells[idx] = key;
			held++;
		endfunction

		function logic signed [KEY_W-1:0] take(int idx);
			logic signed [KEY_W-1:0] k;
			k = cells[idx];
			for (int i = idx; i + 1 < held; i++)
				cells[i] = cells[i+1];
			held--;
			return k;
		endfunction

		// Work out the results of one accepted command and update the list.
		function void apply_command(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] key);
			logic [STATUS_W-1:0] st;
			logic signed [KEY_W-1:0] removed;
			logic signed [KEY_W-1:0] t;
			int idx;
			st = ST_OK;
			removed = '0;
			case (act)
				ACT_CLEAR: held = 0;
				ACT_SORT_INS, ACT_TAIL_INS, ACT_HEAD_INS: begin
					if (held >= CAP) begin
						st = ST_FULL;
					end else if (act == ACT_SORT_INS) begin
						idx = 0;
						while (idx < held && cells[idx] < key)
							idx++;
						place(idx, key);
					end else if (act == ACT_TAIL_INS) begin
						place(held, key);
					end else begin
						place(0, key);
					end
				end
				ACT_DEL_KEY: begin
					if (held == 0) begin
						st = ST_EMPTY;
					end else begin
						idx = 0;
						while (idx < held && cells[idx] != key)
							idx++;
						if (idx < held)
							removed = take(idx);
						else
							st = ST_NOTFOUND;
					end
				end
				ACT_DEL_HEAD, ACT_DEL_TAIL: begin
					if (held == 0)
						st = ST_EMPTY;
					else
						removed = take(act == ACT_DEL_HEAD ? 0 : held - 1);
				end
				ACT_REVERSE: begin
					if (held == 0) begin
						st = ST_EMPTY;
					end else begin
						for (int i = 0; i < held / 2; i++) begin
							t = cells[i];
							cells[i] = cells[held-1-i];
							cells[held-1-i] = t;
						end
					end
				end
				ACT_DUMP: begin
					if (held == 0) begin
						push(ST_EMPTY, '0, 0, 1'b1);
					end else begin
						for (int i = 0; i < held; i++)
							push(ST_OK, cells[i], i, i + 1 == held);
					end
					return;
				end
				default: ;
			endcase
			push(st, removed, 0, 1'b1);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (due.size() == 0) begin
				$error("unexpected result: status %0d key %0d", got.status, got.key);
				fails++;
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				fails++;
			end
			if (got.key !== want.key) begin
				$error("key_out: expected %0d, actual %0d", want.key, got.key);
				fails++;
			end
			if (got.pos !== want.pos) begin
				$error("position: expected %0d, actual %0d", want.pos, got.pos);
				fails++;
			end
			if (got.count !== want.count) begin
				$error("entry_count: expected %0d, actual %0d", want.count, got.count);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				fails++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [ACT_W-1:0]           action;
	logic signed [KEY_W-1:0]    new_key;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic signed [KEY_W-1:0]    key_out;
	logic [POS_W-1:0]           position;
	logic [ENTRY_W-1:0]         entry_count;
	logic                       last;

	key_list_tracker tracker;
	int idle_pct;

	ordered_key_list_engine #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.new_key(new_key),
		.done(done),
		.status(status),
		.key_out(key_out),
		.position(position),
		.entry_count(entry_count),
		.last(last)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result('{status, key_out, position, entry_count, last});
	end

	// Random idle cycles, then hold the command until the transfer happens.
	task automatic issue(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] key);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		new_key <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.apply_command(act, key);
	endtask

	// Favor keys already held so deletes hit, and small values so duplicates occur.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40 && tracker.held > 0)
			return tracker.cells[$urandom_range(tracker.held - 1)];
		if (r < 60)
			return KEY_W'(int'($urandom_range(16)) - 8);
		if (r < 75) begin
			case ($urandom_range(3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	// ins_pct steers the list toward full or toward empty.
	function automatic logic [ACT_W-1:0] pick_action(int ins_pct);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return ACT_UNUSED_LO + ACT_W'($urandom_range(ACT_UNUSED_HI - ACT_UNUSED_LO));
		if (r < 5)
			return ACT_CLEAR;
		if (r < 12)
			return ACT_DUMP;
		if (r < 16)
			return ACT_REVERSE;
		r = $urandom_range(2);
		if ($urandom_range(99) < ins_pct)
			return r == 0 ? ACT_TAIL_INS : r == 1 ? ACT_HEAD_INS : ACT_SORT_INS;
		return r == 0 ? ACT_DEL_HEAD : r == 1 ? ACT_DEL_TAIL : ACT_DEL_KEY;
	endfunction

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int phase_pct [3];
		int ins_pct;
		int run_len;
		int sent;
		phase_pct = '{16, 61, 0};
		tracker = new();
		idle_pct = phase_pct[0];
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_CLEAR;
		new_key <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list cases, meaningless actions, extreme and equal keys.
		issue(ACT_DUMP, '0);
		issue(ACT_DEL_KEY, '0);
		issue(ACT_DEL_HEAD, '0);
		issue(ACT_DEL_TAIL, '0);
		issue(ACT_REVERSE, '0);
		issue(ACT_UNUSED_LO, KEY_MAX);
		issue(ACT_UNUSED_HI, KEY_MIN);
		issue(ACT_SORT_INS, '0);
		issue(ACT_SORT_INS, KEY_MAX);
		issue(ACT_SORT_INS, KEY_MIN);
		issue(ACT_SORT_INS, '1);
		issue(ACT_SORT_INS, '0);
		issue(ACT_HEAD_INS, 32'h5555_5555);
		issue(ACT_TAIL_INS, 32'hAAAA_AAAA);
		issue(ACT_DUMP, '0);
		issue(ACT_DEL_KEY, 32'sd1234);
		issue(ACT_DEL_KEY, '0);
		issue(ACT_REVERSE, '0);
		issue(ACT_DUMP, '0);
		issue(ACT_DEL_HEAD, '0);
		issue(ACT_DEL_TAIL, '0);
		issue(ACT_CLEAR, '0);
		issue(ACT_DUMP, '0);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = phase_pct[ph];
			sent = 0;
			ins_pct = 90;
			run_len = 24;
			while (sent < 58) begin
				for (int i = 0; i < run_len; i++)
					issue(pick_action(ins_pct), pick_key());
				sent += run_len;
				case ($urandom_range(2))
					0: ins_pct = 90;
					1: ins_pct = 20;
					default: ins_pct = 55;
				endcase
				run_len = $urandom_range(30, 10);
			end
		end
		start <= 1'b0;

		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
